FILE: hw/rtl/lscp_pkg.sv
// Shared types, widths and constants for the line sensor calibration and position block.
// Used by lscp_divider and line_sensor_calibrate_position_core; depends on nothing else.
`timescale 1ns / 1ps

package lscp_pkg;

    localparam int NUM_SENSORS  = 8;
    localparam int READING_BITS = 16;
    localparam int FULL_SCALE   = 1000;

    localparam int CH_BITS     = $clog2(NUM_SENSORS);
    localparam int SCALED_BITS = $clog2(FULL_SCALE + 1);
    localparam int SUM_BITS    = $clog2(NUM_SENSORS * FULL_SCALE + 1);
    localparam int POS_BITS    = $clog2((NUM_SENSORS - 1) * FULL_SCALE + 1);
    localparam int MEAN_BITS   = SCALED_BITS;

    localparam longint MAX_READING  = (longint'(1) << READING_BITS) - 1;
    localparam int     PRODUCT_BITS = $clog2(longint'(FULL_SCALE) * MAX_READING + 1);
    localparam int     WEIGHTED_BITS =
        $clog2(longint'(NUM_SENSORS - 1) * FULL_SCALE * NUM_SENSORS * FULL_SCALE + 1);

    localparam int DIVIDEND_BITS = (PRODUCT_BITS > WEIGHTED_BITS) ? PRODUCT_BITS
                                                                  : WEIGHTED_BITS;
    localparam int DIVISOR_BITS  = (READING_BITS > SUM_BITS) ? READING_BITS : SUM_BITS;
    localparam int QUOT_BITS     = (POS_BITS > SCALED_BITS) ? POS_BITS : SCALED_BITS;
    localparam int DEN_BITS      = DIVISOR_BITS + QUOT_BITS - 1;
    localparam int CNT_BITS      = $clog2(QUOT_BITS + 1);

    localparam int IN_TDATA_BITS  = ((NUM_SENSORS * READING_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = POS_BITS + MEAN_BITS + 1;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAL,
        ST_LOAD,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_ACC,
        ST_WADD,
        ST_PSTART,
        ST_PDIV,
        ST_DONE
    } lscp_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } lscp_div_status_t;

    // Position weight of a channel: its index times the full scale.
    function automatic logic [POS_BITS-1:0] channel_weight(input logic [CH_BITS-1:0] ch);
        return POS_BITS'(int'(ch) * FULL_SCALE);
    endfunction

endpackage

FILE: hw/rtl/line_sensor_calibrate_position_core.sv
// Top level of the reflectance line sensor calibration and weighted position block.
// Depends on lscp_pkg and instantiates lscp_divider.
`timescale 1ns / 1ps

// Each input word on the s_ channel is one frame of eight sensor readings.
// The cfg_ channel writes the calibrate_mode register (reset value 1); it is
// always ready and should only be written while the block is idle.
// In calibrate mode the first frame after reset seeds each channel's minimum
// and maximum, and later frames widen them. One result word is returned with
// tuser set and all other fields zero.
// In run mode each reading is clamped and scaled to 0..1000, and the result
// word carries the weighted line position, the mean scaled level and a
// no-line flag.
// Sequence: a calibrate frame updates one channel per cycle and then reaches the
// result register. A run frame steps through each channel in turn: load, multiply,
// start, the shared restoring divider (13 steps, then its done strobe), accumulate
// and add; then come the position division and the result, with the division
// skipped when no line is seen.
// Only one frame is in flight and s_tready is high only while the sequencer is idle,
// so a new frame is taken only after the previous one has reached the result register.
// The result sits in an output register, so a new frame may be accepted while
// the previous word waits for m_tready; a finished word then waits in turn.
// Reset clears the sequencer, the output valid and the seeded flag, and sets
// calibrate mode; the stored ranges are undefined until the first calibrate frame.

module line_sensor_calibrate_position_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input frame.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // reading_zero [15:0], reading_one, ... up to reading_seven [127:112].
    input  logic [lscp_pkg::IN_TDATA_BITS-1:0]    s_tdata,
    // Result.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // line_position [12:0], mean_level [22:13], no_line [23].
    output logic [lscp_pkg::OUT_TDATA_BITS-1:0]   m_tdata,
    // calibrating [0].
    output logic [0:0]                            m_tuser,
    // Configuration write of calibrate_mode.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic                                  cfg_data
);

    localparam int RB = lscp_pkg::READING_BITS;
    localparam int NS = lscp_pkg::NUM_SENSORS;

    lscp_pkg::lscp_state_t state_reg, state_next;

    logic [lscp_pkg::CH_BITS-1:0] ch_reg, ch_next;
    logic                         seeded_reg, seeded_next;
    logic                         calmode_reg;
    logic                         m_tvalid_reg, m_tvalid_next;

    // Frame and per-channel ranges.
    logic [RB-1:0] frame_reg [NS];
    logic [RB-1:0] min_reg [NS];
    logic [RB-1:0] max_reg [NS];
    logic          min_we, max_we;

    // Run datapath.
    logic                                  cal_item_reg, cal_item_next;
    logic [RB-1:0]                         diff_reg, diff_next;
    logic [RB-1:0]                         span_reg, span_next;
    logic                                  zero_reg, zero_next;
    logic [lscp_pkg::PRODUCT_BITS-1:0]     num_reg, num_next;
    logic [lscp_pkg::SUM_BITS-1:0]         sum_reg, sum_next;
    logic [lscp_pkg::WEIGHTED_BITS-1:0]    prod_reg, prod_next;
    logic [lscp_pkg::WEIGHTED_BITS-1:0]    weighted_reg, weighted_next;

    // Result register.
    logic [lscp_pkg::POS_BITS-1:0]         pos_reg, pos_next;
    logic [lscp_pkg::MEAN_BITS-1:0]        mean_reg, mean_next;
    logic                                  noline_reg, noline_next;
    logic                                  calibrating_reg, calibrating_next;

    // Divider hookup.
    logic                                  div_start;
    logic [lscp_pkg::DIVIDEND_BITS-1:0]    div_dividend;
    logic [lscp_pkg::DIVISOR_BITS-1:0]     div_divisor;
    logic [lscp_pkg::QUOT_BITS-1:0]        div_quotient;
    lscp_pkg::lscp_div_status_t            div_status;

    // Values read at the current channel.
    logic [RB-1:0]                         cur_v, cur_lo, cur_hi, cur_clamped;
    logic [lscp_pkg::SCALED_BITS-1:0]      scaled;
    logic [lscp_pkg::SUM_BITS-1:0]         mean_full;
    logic                                  last_ch;
    logic                                  s_accept;

    assign s_accept    = s_tvalid && s_tready;
    assign cur_v       = frame_reg[ch_reg];
    assign cur_lo      = min_reg[ch_reg];
    assign cur_hi      = max_reg[ch_reg];
    assign last_ch     = (ch_reg == lscp_pkg::CH_BITS'(NS - 1));
    assign cur_clamped = (cur_v < cur_lo) ? cur_lo : ((cur_v > cur_hi) ? cur_hi : cur_v);
    // A channel with no range scales to zero whatever the divider returned.
    assign scaled      = zero_reg ? '0 : div_quotient[lscp_pkg::SCALED_BITS-1:0];
    assign mean_full   = sum_reg / lscp_pkg::SUM_BITS'(lscp_pkg::NUM_SENSORS);

    lscp_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_status)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lscp_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = calmode_reg ? lscp_pkg::ST_CAL : lscp_pkg::ST_LOAD;
                end
            end
            lscp_pkg::ST_CAL:
            begin
                if (last_ch)
                begin
                    state_next = lscp_pkg::ST_DONE;
                end
            end
            lscp_pkg::ST_LOAD:   state_next = lscp_pkg::ST_MUL;
            lscp_pkg::ST_MUL:    state_next = lscp_pkg::ST_START;
            lscp_pkg::ST_START:  state_next = lscp_pkg::ST_DIV;
            lscp_pkg::ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = lscp_pkg::ST_ACC;
                end
            end
            lscp_pkg::ST_ACC:    state_next = lscp_pkg::ST_WADD;
            lscp_pkg::ST_WADD:
            begin
                state_next = last_ch ? lscp_pkg::ST_PSTART : lscp_pkg::ST_LOAD;
            end
            lscp_pkg::ST_PSTART:
            begin
                // With no line seen there is nothing to divide.
                state_next = (sum_reg == '0) ? lscp_pkg::ST_DONE : lscp_pkg::ST_PDIV;
            end
            lscp_pkg::ST_PDIV:
            begin
                if (div_status.done)
                begin
                    state_next = lscp_pkg::ST_DONE;
                end
            end
            lscp_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = lscp_pkg::ST_IDLE;
                end
            end
            default:             state_next = lscp_pkg::ST_IDLE;
        endcase
    end

    // Datapath control and next values.
    always_comb
    begin
        ch_next          = ch_reg;
        seeded_next      = seeded_reg;
        cal_item_next    = cal_item_reg;
        diff_next        = diff_reg;
        span_next        = span_reg;
        zero_next        = zero_reg;
        num_next         = num_reg;
        sum_next         = sum_reg;
        prod_next        = prod_reg;
        weighted_next    = weighted_reg;
        pos_next         = pos_reg;
        mean_next        = mean_reg;
        noline_next      = noline_reg;
        calibrating_next = calibrating_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        min_we           = 1'b0;
        max_we           = 1'b0;
        div_start        = 1'b0;
        div_dividend     = lscp_pkg::DIVIDEND_BITS'(num_reg);
        div_divisor      = lscp_pkg::DIVISOR_BITS'(span_reg);
        s_tready         = 1'b0;

        case (state_reg)
            lscp_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_accept)
                begin
                    ch_next       = '0;
                    cal_item_next = calmode_reg;
                    sum_next      = '0;
                    weighted_next = '0;
                end
            end
            lscp_pkg::ST_CAL:
            begin
                // The first calibrate frame seeds both bounds; later ones widen them.
                if (!seeded_reg)
                begin
                    min_we = 1'b1;
                    max_we = 1'b1;
                end
                else if (cur_v < cur_lo)
                begin
                    min_we = 1'b1;
                end
                else if (cur_v > cur_hi)
                begin
                    max_we = 1'b1;
                end
                ch_next = ch_reg + lscp_pkg::CH_BITS'(1);
                if (last_ch)
                begin
                    seeded_next = 1'b1;
                end
            end
            lscp_pkg::ST_LOAD:
            begin
                zero_next = (cur_hi <= cur_lo);
                diff_next = cur_clamped - cur_lo;
                span_next = cur_hi - cur_lo;
            end
            lscp_pkg::ST_MUL:
            begin
                num_next = lscp_pkg::PRODUCT_BITS'(diff_reg)
                         * lscp_pkg::PRODUCT_BITS'(lscp_pkg::FULL_SCALE);
            end
            lscp_pkg::ST_START:
            begin
                div_start = 1'b1;
            end
            lscp_pkg::ST_ACC:
            begin
                sum_next  = sum_reg + lscp_pkg::SUM_BITS'(scaled);
                prod_next = lscp_pkg::WEIGHTED_BITS'(lscp_pkg::channel_weight(ch_reg))
                          * lscp_pkg::WEIGHTED_BITS'(scaled);
            end
            lscp_pkg::ST_WADD:
            begin
                weighted_next = weighted_reg + prod_reg;
                ch_next       = ch_reg + lscp_pkg::CH_BITS'(1);
            end
            lscp_pkg::ST_PSTART:
            begin
                div_dividend = lscp_pkg::DIVIDEND_BITS'(weighted_reg);
                div_divisor  = lscp_pkg::DIVISOR_BITS'(sum_reg);
                div_start    = (sum_reg != '0);
            end
            lscp_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next    = 1'b1;
                    calibrating_next = cal_item_reg;
                    if (cal_item_reg)
                    begin
                        pos_next    = '0;
                        mean_next   = '0;
                        noline_next = 1'b0;
                    end
                    else
                    begin
                        noline_next = (sum_reg == '0);
                        pos_next    = (sum_reg == '0) ? '0
                                    : div_quotient[lscp_pkg::POS_BITS-1:0];
                        mean_next   = mean_full[lscp_pkg::MEAN_BITS-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lscp_pkg::ST_IDLE;
            ch_reg       <= '0;
            seeded_reg   <= 1'b0;
            calmode_reg  <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ch_reg       <= ch_next;
            seeded_reg   <= seeded_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                calmode_reg <= cfg_data;
            end
        end
    end

    // Payload registers: frame, ranges and working values.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            for (int i = 0; i < NS; i++)
            begin
                frame_reg[i] <= s_tdata[i*RB +: RB];
            end
        end
        if (min_we)
        begin
            min_reg[ch_reg] <= cur_v;
        end
        if (max_we)
        begin
            max_reg[ch_reg] <= cur_v;
        end
        cal_item_reg    <= cal_item_next;
        diff_reg        <= diff_next;
        span_reg        <= span_next;
        zero_reg        <= zero_next;
        num_reg         <= num_next;
        sum_reg         <= sum_next;
        prod_reg        <= prod_next;
        weighted_reg    <= weighted_next;
        pos_reg         <= pos_next;
        mean_reg        <= mean_next;
        noline_reg      <= noline_next;
        calibrating_reg <= calibrating_next;
    end

    assign cfg_ready  = 1'b1;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = lscp_pkg::OUT_TDATA_BITS'({noline_reg, mean_reg, pos_reg});
    assign m_tuser[0] = calibrating_reg;

endmodule

FILE: hw/rtl/lscp_divider.sv
// Restoring divider, one quotient bit per cycle, shared by the scaling and position divisions of the block.
// Depends on lscp_pkg for its widths and the status struct.
`timescale 1ns / 1ps

module lscp_divider
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [lscp_pkg::DIVIDEND_BITS-1:0]   dividend,
    input  logic [lscp_pkg::DIVISOR_BITS-1:0]    divisor,
    output logic [lscp_pkg::QUOT_BITS-1:0]       quotient,
    output lscp_pkg::lscp_div_status_t           status
);

    // The quotient is known to fit in QUOT_BITS, so the divisor starts
    // shifted up by QUOT_BITS-1 places and walks down one place a cycle.
    logic [lscp_pkg::DIVIDEND_BITS-1:0] rem_reg, rem_next;
    logic [lscp_pkg::DEN_BITS-1:0]      den_reg, den_next;
    logic [lscp_pkg::QUOT_BITS-1:0]     quot_reg, quot_next;
    logic [lscp_pkg::CNT_BITS-1:0]      cnt_reg, cnt_next;
    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [lscp_pkg::DEN_BITS-1:0]      rem_ext;
    logic [lscp_pkg::DEN_BITS-1:0]      sub;

    assign rem_ext = lscp_pkg::DEN_BITS'(rem_reg);
    assign sub     = rem_ext - den_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend;
            den_next  = {divisor, {(lscp_pkg::QUOT_BITS - 1){1'b0}}};
            quot_next = '0;
            cnt_next  = lscp_pkg::CNT_BITS'(lscp_pkg::QUOT_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_ext >= den_reg)
            begin
                rem_next  = sub[lscp_pkg::DIVIDEND_BITS-1:0];
                quot_next = {quot_reg[lscp_pkg::QUOT_BITS-2:0], 1'b1};
            end
            else
            begin
                quot_next = {quot_reg[lscp_pkg::QUOT_BITS-2:0], 1'b0};
            end
            den_next = den_reg >> 1;
            cnt_next = cnt_reg - lscp_pkg::CNT_BITS'(1);
            if (cnt_reg == lscp_pkg::CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign quotient    = quot_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
